// ----- rtl/core/orb_pkg.sv -----
// Shared types and constants for the overwriting ring buffer.
package orb_pkg;

	// Fixed field widths of the request and response records
	localparam int SAMPLE_FIELD_W = 64;
	localparam int COUNT_W        = 7;

	// Request kinds
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	typedef struct packed {
		logic                      req_type;
		logic [SAMPLE_FIELD_W-1:0] sample_in;
		logic [COUNT_W-1:0]        max_count;
	} req_t;

	typedef struct packed {
		logic [SAMPLE_FIELD_W-1:0] sample_out;
		logic                      has_sample;
		logic                      is_last;
		logic [COUNT_W-1:0]        removed_so_far;
	} rsp_t;

	// Controls broadcast along the cell chain
	typedef struct packed {
		logic shift; // every cell takes its neighbor's record
		logic push;  // the cell at the tail index loads the new sample
	} chain_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

endpackage

// ----- rtl/core/orb_cell.sv -----
// One storage cell of the sample chain: holds one record, shifts toward the head.
module orb_cell import orb_pkg::*; #(
	parameter int SAMPLE_WIDTH = 64,
	parameter int IDX_W        = 8,
	parameter int IDX          = 0
) (
	input  logic                    clk,
	input  chain_ctl_t              ctl,
	input  logic [IDX_W-1:0]        tail,
	input  logic [SAMPLE_WIDTH-1:0] sample_in,
	input  logic [SAMPLE_WIDTH-1:0] next_data,
	output logic [SAMPLE_WIDTH-1:0] data
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [SAMPLE_WIDTH-1:0] data_q;

	// A load at the tail wins over the shift (push into a full chain)
	always_ff @(posedge clk) begin
		if (ctl.push && (tail == MY_IDX)) begin
			data_q <= sample_in;
		end else if (ctl.shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

// ----- rtl/core/orb_ctrl.sv -----
// Fill count, pop sequencer and response register for the ring buffer.
module orb_ctrl import orb_pkg::*; #(
	parameter int DEPTH        = 256,
	parameter int SAMPLE_WIDTH = 64,
	parameter int MAX_BATCH    = 64,
	parameter int IDX_W        = 8,
	parameter int FILL_W       = 9
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  req_t                    req,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output rsp_t                    rsp,
	input  logic [SAMPLE_WIDTH-1:0] head_data,
	output chain_ctl_t              ctl,
	output logic [IDX_W-1:0]        tail
);

	localparam int CMP_W = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;
	localparam logic [FILL_W-1:0]  FULL_CNT  = FILL_W'(DEPTH);
	localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(DEPTH - 1);
	localparam logic [COUNT_W-1:0] BATCH_CAP = COUNT_W'(MAX_BATCH);
	localparam logic [COUNT_W-1:0] ONE       = COUNT_W'(1);

	state_t               state_q, state_d;
	logic [FILL_W-1:0]    fill_q, fill_d;
	logic [COUNT_W-1:0]   remain_q, remain_d;
	logic [COUNT_W-1:0]   removed_q, removed_d;
	logic                 rsp_valid_q, rsp_valid_d;
	rsp_t                 rsp_q, rsp_d;

	logic                 full;
	logic                 out_free;
	logic                 accept;
	logic                 do_push;
	logic                 do_pop;
	logic                 pop_step;
	logic [COUNT_W-1:0]   want;
	logic [CMP_W-1:0]     want_ext;
	logic [CMP_W-1:0]     fill_ext;
	logic [COUNT_W-1:0]   take;

	// Batch size: saturate the request, then clip to what is stored
	always_comb begin
		want     = (req.max_count > BATCH_CAP) ? BATCH_CAP : req.max_count;
		want_ext = CMP_W'(want);
		fill_ext = CMP_W'(fill_q);
		take     = (want_ext < fill_ext) ? want : fill_ext[COUNT_W-1:0];
	end

	assign full     = (fill_q == FULL_CNT);
	assign out_free = !rsp_valid_q || rsp_ready;
	assign tail     = full ? LAST_IDX : fill_q[IDX_W-1:0];

	// Next state, handshake and response
	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		remain_d    = remain_q;
		removed_d   = removed_q;
		rsp_valid_d = rsp_valid_q;
		rsp_d       = rsp_q;
		req_ready   = 1'b0;
		pop_step    = 1'b0;

		if (rsp_ready) begin
			rsp_valid_d = 1'b0;
		end

		unique case (state_q)
			ST_IDLE: begin
				req_ready = (req.req_type == REQ_PUSH) || out_free;
			end
			ST_POP: begin
				req_ready = 1'b0;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase

		accept  = req_valid && req_ready;
		do_push = accept && (req.req_type == REQ_PUSH);
		do_pop  = accept && (req.req_type == REQ_POP);

		unique case (state_q)
			ST_IDLE: begin
				if (do_pop) begin
					rsp_valid_d = 1'b1;
					if (take == '0) begin
						// Nothing to remove: one empty, final result
						rsp_d.sample_out     = '0;
						rsp_d.has_sample     = 1'b0;
						rsp_d.is_last        = 1'b1;
						rsp_d.removed_so_far = '0;
					end else begin
						pop_step             = 1'b1;
						rsp_d.sample_out     = SAMPLE_FIELD_W'(head_data);
						rsp_d.has_sample     = 1'b1;
						rsp_d.is_last        = (take == ONE);
						rsp_d.removed_so_far = ONE;
						removed_d            = ONE;
						remain_d             = take - ONE;
						if (take != ONE) begin
							state_d = ST_POP;
						end
					end
				end
			end
			ST_POP: begin
				if (out_free) begin
					pop_step             = 1'b1;
					rsp_valid_d          = 1'b1;
					rsp_d.sample_out     = SAMPLE_FIELD_W'(head_data);
					rsp_d.has_sample     = 1'b1;
					rsp_d.is_last        = (remain_q == ONE);
					rsp_d.removed_so_far = removed_q + ONE;
					removed_d            = removed_q + ONE;
					remain_d             = remain_q - ONE;
					if (remain_q == ONE) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Fill count: a push into a full chain keeps it at DEPTH
		if (do_push && !full) begin
			fill_d = fill_q + FILL_W'(1);
		end else if (pop_step) begin
			fill_d = fill_q - FILL_W'(1);
		end

		ctl.push  = do_push;
		ctl.shift = pop_step || (do_push && full);
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			remain_q    <= '0;
			removed_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			remain_q    <= remain_d;
			removed_q   <= removed_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/core/overwriting_ring_buffer.sv -----
// Top level of the overwriting ring buffer: cell chain plus controller.
//
// Circular sample buffer of DEPTH records built as a chain of cells with the
// oldest record always in cell 0. On a push request the sample lands in the
// cell after the newest one, or, when the buffer is full, the whole chain
// moves one cell toward the head and the sample lands in the last cell,
// dropping the oldest. A pop request of n samples (n the smaller of
// max_count, MAX_BATCH and the fill) gives n responses, one per cycle while
// the response side keeps up, each taken from cell 0 as the chain shifts; a
// pop that can remove nothing gives one empty final response. No new request
// is taken until the last response of a pop is in the output register; a push
// is taken even while a response waits. The chain needs no clearing after
// reset, so the block takes requests as soon as reset is released.
module overwriting_ring_buffer import orb_pkg::*; #(
	parameter int DEPTH        = 256,
	parameter int SAMPLE_WIDTH = 64,
	parameter int MAX_BATCH    = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	chain_ctl_t              ctl;
	logic [IDX_W-1:0]        tail;
	logic [SAMPLE_WIDTH-1:0] sample_w;
	logic [SAMPLE_WIDTH-1:0] cell_data [DEPTH+1];

	assign sample_w         = req.sample_in[SAMPLE_WIDTH-1:0];
	assign cell_data[DEPTH] = '0;

	orb_ctrl #(
		.DEPTH        (DEPTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.MAX_BATCH    (MAX_BATCH),
		.IDX_W        (IDX_W),
		.FILL_W       (FILL_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.head_data (cell_data[0]),
		.ctl       (ctl),
		.tail      (tail)
	);

	// Chain of storage cells, cell 0 at the head
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		orb_cell #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.IDX_W        (IDX_W),
			.IDX          (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.tail      (tail),
			.sample_in (sample_w),
			.next_data (cell_data[i+1]),
			.data      (cell_data[i])
		);
	end

endmodule

// ----- test/tb_overwriting_ring_buffer.sv -----
// Testbench for the overwriting ring buffer: random push/pop traffic checked against a ring model.
module tb_overwriting_ring_buffer;
	import orb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = 256;
	localparam int SAMPLE_WIDTH = 64;
	localparam int MAX_BATCH    = 64;
	localparam int HALF_PERIOD  = 4;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AT_RSP  = 60;
	localparam int DRAIN_CYCLES = 50;

	// One queued request plus the idle cycles the sender waits before offering it
	typedef struct {
		req_t        item;
		int unsigned lead_gap;
	} pending_req_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	pending_req_t pending_reqs[$];
	rsp_t         awaited_rsps[$];

	// Ring model state
	logic [SAMPLE_WIDTH-1:0] ring_mem [DEPTH];
	int unsigned             wr_idx;
	int unsigned             rd_idx;
	int unsigned             fill;

	int unsigned err_count;
	int unsigned lead_idle;
	int unsigned rsp_seen;
	int unsigned rsp_cycle;
	int unsigned stall_left;
	int unsigned hold_left;
	bit          hold_done;

	overwriting_ring_buffer #(
		.DEPTH       (DEPTH),
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.MAX_BATCH   (MAX_BATCH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #HALF_PERIOD clk = ~clk;

	// Idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic queue_req(input logic kind, input logic [63:0] sample,
			input logic [COUNT_W-1:0] count, input int unsigned gap);
		pending_req_t p;
		p.item.req_type  = kind;
		p.item.sample_in = sample;
		p.item.max_count = count;
		p.lead_gap       = gap;
		pending_reqs.push_back(p);
	endtask

	// Apply one accepted request to the ring and queue the responses it must give
	task automatic ring_apply(input req_t r);
		int unsigned want;
		int unsigned take;
		rsp_t        o;
		if (r.req_type == REQ_PUSH) begin
			ring_mem[wr_idx] = r.sample_in[SAMPLE_WIDTH-1:0];
			wr_idx = (wr_idx + 1) % DEPTH;
			if (fill < DEPTH)
				fill++;
			else
				rd_idx = (rd_idx + 1) % DEPTH;
			return;
		end
		want = r.max_count;
		if (want > MAX_BATCH)
			want = MAX_BATCH;
		take = (want < fill) ? want : fill;
		if (take == 0) begin
			o = '0;
			o.is_last = 1'b1;
			awaited_rsps.push_back(o);
			return;
		end
		for (int unsigned i = 0; i < take; i++) begin
			o = '0;
			o.sample_out     = ring_mem[rd_idx];
			o.has_sample     = 1'b1;
			o.is_last        = (i + 1 == take);
			o.removed_so_far = COUNT_W'(i + 1);
			awaited_rsps.push_back(o);
			rd_idx = (rd_idx + 1) % DEPTH;
			fill--;
		end
	endtask

	task automatic check_rsp(input rsp_t got);
		rsp_t want;
		if (awaited_rsps.size() == 0) begin
			$display("%0t: unexpected response, expected none, actual %p", $realtime, got);
			err_count++;
			return;
		end
		want = awaited_rsps.pop_front();
		if (got.sample_out !== want.sample_out) begin
			$display("%0t: sample_out expected %h actual %h", $realtime,
				want.sample_out, got.sample_out);
			err_count++;
		end
		if (got.has_sample !== want.has_sample) begin
			$display("%0t: has_sample expected %b actual %b", $realtime,
				want.has_sample, got.has_sample);
			err_count++;
		end
		if (got.is_last !== want.is_last) begin
			$display("%0t: is_last expected %b actual %b", $realtime,
				want.is_last, got.is_last);
			err_count++;
		end
		if (got.removed_so_far !== want.removed_so_far) begin
			$display("%0t: removed_so_far expected %0d actual %0d", $realtime,
				want.removed_so_far, got.removed_so_far);
			err_count++;
		end
	endtask

	// Request driver: offers queued requests, models each one on acceptance
	always @(posedge clk or negedge arst_n) begin
		logic busy;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			lead_idle = 0;
		end else begin
			busy = req_valid;
			if (req_valid && req_ready) begin
				ring_apply(req);
				busy = 1'b0;
			end
			if (!busy && pending_reqs.size() > 0) begin
				if (lead_idle < pending_reqs[0].lead_gap) begin
					lead_idle++;
				end else begin
					req <= pending_reqs.pop_front().item;
					lead_idle = 0;
					busy = 1'b1;
				end
			end
			req_valid <= busy;
		end
	end

	// Response monitor: checks accepted responses and throttles ready
	always @(posedge clk or negedge arst_n) begin
		logic next_ready;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_seen   = 0;
			rsp_cycle  = 0;
			stall_left = 0;
			hold_left  = 0;
			hold_done  = 1'b0;
		end else begin
			rsp_cycle++;
			if (rsp_valid && rsp_ready) begin
				check_rsp(rsp);
				rsp_seen++;
				// while (rsp_cycle / 200) % 4 is zero, responses are taken without stalls
				stall_left = ((rsp_cycle / 200) % 4 == 0) ? 0 : pick_gap();
				// one long hold-off so the block fills up and blocks new requests
				if (!hold_done && rsp_seen == HOLD_AT_RSP) begin
					hold_left = HOLD_CYCLES;
					hold_done = 1'b1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
			end
			rsp_ready <= next_ready;
		end
	end

	// Stimulus and end of run
	initial begin
		int unsigned r;
		logic [COUNT_W-1:0] cnt;
		err_count = 0;
		wr_idx = 0;
		rd_idx = 0;
		fill = 0;

		// Directed: pops on an empty ring, field extremes, saturation, short fills
		queue_req(REQ_POP, '0, 7'd0, 0);
		queue_req(REQ_POP, '1, 7'd1, 0);
		queue_req(REQ_POP, '0, 7'd127, 0);
		queue_req(REQ_PUSH, 64'h0, 7'd127, 0);
		queue_req(REQ_PUSH, '1, 7'd0, 0);
		queue_req(REQ_PUSH, 64'hA5A5_A5A5_A5A5_A5A5, 7'd85, 1);
		queue_req(REQ_PUSH, 64'h5A5A_5A5A_5A5A_5A5A, 7'd42, 0);
		queue_req(REQ_POP, rand64(), 7'd0, 0);
		queue_req(REQ_POP, rand64(), 7'd1, 0);
		queue_req(REQ_POP, rand64(), 7'd127, 2);
		for (int i = 0; i < 5; i++)
			queue_req(REQ_PUSH, rand64(), 7'($urandom), 0);
		queue_req(REQ_POP, rand64(), 7'd64, 0);
		for (int i = 0; i < 3; i++)
			queue_req(REQ_PUSH, rand64(), 7'($urandom), 0);
		queue_req(REQ_POP, rand64(), 7'd2, 0);
		queue_req(REQ_POP, rand64(), 7'd1, 0);
		queue_req(REQ_POP, rand64(), 7'd100, 0);

		// Fill phase: mostly pushes, enough to wrap the ring and overwrite
		for (int i = 0; i < 300; i++) begin
			if ($urandom_range(0, 99) < 95)
				queue_req(REQ_PUSH, rand64(), 7'($urandom),
					((i / 50) % 3 == 0) ? 0 : pick_gap());
			else
				queue_req(REQ_POP, rand64(), 7'($urandom_range(0, 2)),
					((i / 50) % 3 == 0) ? 0 : pick_gap());
		end

		// Mixed phase: batch pops of every size against ongoing pushes
		for (int i = 0; i < 150; i++) begin
			if ($urandom_range(0, 1) == 0) begin
				queue_req(REQ_PUSH, rand64(), 7'($urandom),
					((i / 50) % 3 == 1) ? 0 : pick_gap());
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10)
					cnt = 7'd0;
				else if (r < 30)
					cnt = 7'd1;
				else if (r < 70)
					cnt = 7'($urandom_range(2, MAX_BATCH));
				else
					cnt = 7'($urandom_range(MAX_BATCH + 1, 127));
				queue_req(REQ_POP, rand64(), cnt,
					((i / 50) % 3 == 1) ? 0 : pick_gap());
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Checked between edges, once the driver and monitor have settled
		while (pending_reqs.size() > 0 || req_valid)
			@(negedge clk);
		while (awaited_rsps.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#100_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/orb_pkg.sv
rtl/core/orb_cell.sv
rtl/core/orb_ctrl.sv
rtl/core/overwriting_ring_buffer.sv
test/tb_overwriting_ring_buffer.sv
